FILE: hw/rtl/pp3d_pkg.sv
package pp3d_pkg;

  // Coordinate and arithmetic widths fixed by the point format.
  localparam int COORD_W  = 24;              // signed coordinate
  localparam int MAG_W    = 24;              // |a - b| of two coordinates
  localparam int SQ_W     = 2 * MAG_W;       // one squared component
  localparam int RAD_W    = SQ_W + 2;        // sum of three squares
  localparam int ROOT_W   = RAD_W / 2;       // floor square root
  localparam int SQRT_TOP = RAD_W - 2;       // highest even bit of the radicand

  localparam int IN_DATA_W  = 3 * COORD_W;   // x, y, z
  localparam int OUT_W      = 37;            // perimeter in hundredths
  localparam int OUT_DATA_W = 40;            // OUT_W padded to whole bytes

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // Command from the sequencer to the squared-distance unit.
  typedef struct packed {
    logic start;
    logic use_first;  // 1: distance to the first point, 0: to the previous one
  } dist_cmd_t;

endpackage

FILE: hw/rtl/pp3d_sqdist.sv
module pp3d_sqdist (
  input  logic                       clk,
  input  logic                       rst,
  input  pp3d_pkg::dist_cmd_t        cmd,
  input  pp3d_pkg::point_t           pt_new,
  input  pp3d_pkg::point_t           pt_prev,
  input  pp3d_pkg::point_t           pt_first,
  output logic                       done,
  output logic [pp3d_pkg::RAD_W-1:0] sq_sum
);
  import pp3d_pkg::*;

  // Three-stage pass over the components: difference, square, accumulate.
  localparam logic [2:0] MAG_LAST   = 3'd2;
  localparam logic [2:0] PROD_FIRST = 3'd1;
  localparam logic [2:0] PROD_LAST  = 3'd3;
  localparam logic [2:0] ACC_FIRST  = 3'd2;
  localparam logic [2:0] PASS_LAST  = 3'd4;

  logic             run;
  logic [2:0]       cnt;
  logic             use_first;
  logic [MAG_W-1:0] mag;
  logic [SQ_W-1:0]  prod;
  logic [RAD_W-1:0] acc;

  point_t           pt_ref;
  coord_t           ca;
  coord_t           cb;
  logic [COORD_W:0] diff;
  logic [MAG_W-1:0] mag_next;

  always_comb begin
    pt_ref = use_first ? pt_first : pt_prev;
    case (cnt)
      3'd0: begin
        ca = pt_new.x;
        cb = pt_ref.x;
      end
      3'd1: begin
        ca = pt_new.y;
        cb = pt_ref.y;
      end
      default: begin
        ca = pt_new.z;
        cb = pt_ref.z;
      end
    endcase
    diff     = {ca[COORD_W-1], ca} - {cb[COORD_W-1], cb};
    mag_next = diff[COORD_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == PASS_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      use_first <= cmd.use_first;
      acc       <= '0;
    end else if (run) begin
      if (cnt <= MAG_LAST) begin
        mag <= mag_next;
      end
      if (cnt >= PROD_FIRST && cnt <= PROD_LAST) begin
        prod <= mag * mag;
      end
      if (cnt >= ACC_FIRST) begin
        acc <= acc + RAD_W'(prod);
      end
    end
  end

  assign sq_sum = acc;

endmodule

FILE: hw/rtl/pp3d_isqrt.sv
module pp3d_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pp3d_pkg::RAD_W-1:0]  radicand,
  output logic                        done,
  output logic [pp3d_pkg::ROOT_W-1:0] root
);
  import pp3d_pkg::*;

  // Restoring square root, one result bit per cycle.
  logic             run;
  logic [RAD_W-1:0] rem;
  logic [RAD_W-1:0] acc;
  logic [RAD_W-1:0] bitv;
  logic [RAD_W:0]   trial;
  logic             fits;

  assign trial = {1'b0, acc} + {1'b0, bitv};
  assign fits  = {1'b0, rem} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && bitv[0]) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      acc  <= '0;
      bitv <= RAD_W'(1) << SQRT_TOP;
    end else if (run) begin
      if (fits) begin
        rem <= rem - trial[RAD_W-1:0];
        acc <= (acc >> 1) + bitv;
      end else begin
        acc <= acc >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = acc[ROOT_W-1:0];

endmodule

FILE: hw/rtl/polyline_perimeter_3d_core.sv
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  one point: x, y, z in s_tdata, last point on s_tlast
// m_*       out        m_tvalid / m_tready  perimeter in hundredths, saturation flag on m_tuser
// cfg_*     in         cfg_valid / cfg_ready  closed_mode write
//
// The first point of a polyline is only stored. Every later point runs a segment
// pass: the squared distance on the shared 24x24 multiplier, then the bit-serial
// square root. A last point in closed mode runs that segment pass twice, then
// scales and emits the result. Reset (rst, synchronous) clears the polyline
// state, drops m_tvalid and sets closed_mode to 1. A stalled result word holds on
// m_* while the next points are taken; only the following result waits for
// m_tready.
module polyline_perimeter_3d_core #(
  parameter int FRAC_BITS = 10,
  parameter int SUM_WIDTH = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata from bit 0: x_coord[23:0], y_coord[23:0], z_coord[23:0]
  input  logic [pp3d_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata from bit 0: perimeter_hundredths[36:0], then three zero bits
  output logic [pp3d_pkg::OUT_DATA_W-1:0]  m_tdata,
  // m_tuser: saturated
  output logic                             m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data
);
  import pp3d_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQ    = 3'd1;
  localparam logic [2:0] ST_ROOT  = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  // Width of the scaled sum; wide enough for sum * 100 and for the output slice.
  localparam int PROD_W = (SUM_WIDTH + 7 > OUT_W + FRAC_BITS) ?
                          SUM_WIDTH + 7 : OUT_W + FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF = (FRAC_BITS > 0) ?
      (PROD_W'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  logic [2:0]           state;
  logic                 closed_mode;
  logic                 have_point;
  logic                 is_last;
  logic                 use_first;
  logic                 kick;
  point_t               pt;
  point_t               first_point;
  point_t               previous_point;
  logic [SUM_WIDTH-1:0] length_sum;
  logic                 sum_saturated;
  logic [PROD_W-1:0]    scaled;

  point_t               p_in;
  dist_cmd_t            dcmd;
  logic                 sq_done;
  logic [RAD_W-1:0]     sq_sum;
  logic                 root_done;
  logic [ROOT_W-1:0]    root;
  logic [SUM_WIDTH:0]   sum_total;
  logic [PROD_W-1:0]    sum_ext;
  logic [PROD_W-1:0]    rounded;
  logic                 in_fire;
  logic                 out_free;

  always_comb begin
    p_in.x = s_tdata[COORD_W-1:0];
    p_in.y = s_tdata[2*COORD_W-1:COORD_W];
    p_in.z = s_tdata[3*COORD_W-1:2*COORD_W];
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign dcmd.start     = kick;
  assign dcmd.use_first = use_first;

  // Squared distance between the held point and either the previous or the first point.
  pp3d_sqdist u_sqdist (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dcmd),
    .pt_new   (pt),
    .pt_prev  (previous_point),
    .pt_first (first_point),
    .done     (sq_done),
    .sq_sum   (sq_sum)
  );

  // The square root starts the cycle the squared distance is ready.
  pp3d_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_done),
    .radicand (sq_sum),
    .done     (root_done),
    .root     (root)
  );

  // Saturating add: a carry out means the sum passed its maximum.
  assign sum_total = {1'b0, length_sum} + (SUM_WIDTH + 1)'(root);
  assign sum_ext   = PROD_W'(length_sum);
  assign rounded   = (scaled + HALF) >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      closed_mode   <= 1'b1;
      have_point    <= 1'b0;
      kick          <= 1'b0;
      length_sum    <= '0;
      sum_saturated <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      kick <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        closed_mode <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (!have_point) begin
              // A lone first point adds nothing, open or closed.
              have_point <= 1'b1;
              if (s_tlast) begin
                state <= ST_SCALE;
              end
            end else begin
              kick  <= 1'b1;
              state <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          if (sq_done) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            if (sum_total[SUM_WIDTH]) begin
              length_sum    <= SUM_MAX;
              sum_saturated <= 1'b1;
            end else begin
              length_sum <= sum_total[SUM_WIDTH-1:0];
            end
            if (use_first || (is_last && !closed_mode)) begin
              state <= ST_SCALE;
            end else if (is_last) begin
              // Closing segment back to the first point.
              kick  <= 1'b1;
              state <= ST_SQ;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SCALE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid      <= 1'b1;
            have_point    <= 1'b0;
            length_sum    <= '0;
            sum_saturated <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Data registers, no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pt        <= p_in;
      is_last   <= s_tlast;
      use_first <= 1'b0;
      if (!have_point) begin
        first_point    <= p_in;
        previous_point <= p_in;
      end
    end
    if (state == ST_ROOT && root_done) begin
      if (!use_first) begin
        previous_point <= pt;
        use_first      <= 1'b1;
      end
    end
    if (state == ST_SCALE) begin
      // sum * 100 as sum * 64 + sum * 32 + sum * 4.
      scaled <= (sum_ext << 6) + (sum_ext << 5) + (sum_ext << 2);
    end
    if (state == ST_EMIT && out_free) begin
      m_tdata <= OUT_DATA_W'(rounded[OUT_W-1:0]);
      m_tuser <= sum_saturated;
    end
  end

endmodule

FILE: hw/rtl/pp3d_checker.sv
module pp3d_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pp3d_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser
);
  import pp3d_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // The pad bits above the perimeter are always zero.
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_W] == '0)
    else $error("nonzero pad bits in result word");

  // A last point always leaves the block busy in the cycle after it is taken.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input ready right after a last point");

  // A new result only comes out of the busy phase.
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a busy phase");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind polyline_perimeter_3d_core pp3d_checker u_pp3d_checker (.*);

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Block configuration under test: fixed-point fraction bits and width of the length sum.
  localparam int FRAC_BITS = 10;
  localparam int SUM_WIDTH = 40;

  localparam longint unsigned SUM_LIMIT  = (64'd1 << SUM_WIDTH) - 1;
  localparam longint unsigned ROUND_HALF = 64'd1 << (FRAC_BITS - 1);

  // Extremes of a 24-bit two's complement coordinate.
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  // Values of the closed_mode register.
  localparam bit MODE_OPEN   = 1'b0;
  localparam bit MODE_CLOSED = 1'b1;

  // A point result can be up to two segment passes plus scaling behind the last
  // input word, so this many quiet cycles must pass before touching closed_mode.
  localparam int DRAIN_CYCLES = 120;

  // Length of the one long output stall that forces the block to back up.
  localparam int STALL_CYCLES = 3000;

  // Corner-to-corner hops in the long closed polyline. Each is the largest
  // segment the coordinates allow; clamping the sum would take tens of
  // thousands of them.
  localparam int CORNER_HOPS = 24;

  typedef struct {
    pp3d_pkg::point_t pt;
    bit               last;
  } vertex_t;

  typedef struct {
    logic [pp3d_pkg::OUT_W-1:0] hundredths;
    logic                       sat;
  } perimeter_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [pp3d_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  logic                            s_tlast  = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [pp3d_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_data  = 1'b0;

  // Input words still to be offered, and perimeters the block still owes us.
  vertex_t    pending_points[$];
  perimeter_t pending_perimeters[$];
  vertex_t    on_bus;

  // Shadow of the block's polyline state, as it should be after reset.
  pp3d_pkg::point_t first_pt   = '0;
  pp3d_pkg::point_t prev_pt    = '0;
  bit               have_pt    = 1'b0;
  longint unsigned  length_acc = 0;
  bit               length_sat = 1'b0;
  bit               closed_now = MODE_CLOSED;

  // Traffic shaping; the idle rates and the stall requests change only between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stalls_asked  = 0;
  int stalls_served = 0;
  int stall_left    = 0;

  int fail_count      = 0;
  int points_taken    = 0;
  int results_seen    = 0;
  int saturated_seen  = 0;
  int open_polylines  = 0;
  int closed_polylines = 0;

  polyline_perimeter_3d_core #(
    .FRAC_BITS(FRAC_BITS),
    .SUM_WIDTH(SUM_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Floor square root, built one result bit at a time from the top. The radicand
  // is a sum of three squares of 24-bit magnitudes, so the root fits in 25 bits.
  function automatic longint unsigned floor_sqrt(longint unsigned radicand);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  // Euclidean distance between two points, truncated to whole fixed-point units.
  function automatic longint unsigned segment_length(pp3d_pkg::point_t a, pp3d_pkg::point_t b);
    longint signed dx;
    longint signed dy;
    longint signed dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    return floor_sqrt(dx * dx + dy * dy + dz * dz);
  endfunction

  // The sum clamps at its all-ones value and the flag sticks until the result.
  function automatic void accumulate(longint unsigned seg);
    if (seg > SUM_LIMIT - length_acc) begin
      length_acc = SUM_LIMIT;
      length_sat = 1'b1;
    end else begin
      length_acc += seg;
    end
  endfunction

  // Advance the shadow state by one accepted point and queue the perimeter it
  // produces, if it closes a polyline.
  function automatic void track_vertex(vertex_t v);
    perimeter_t       owed;
    longint unsigned  scaled;
    if (!have_pt) begin
      first_pt = v.pt;
      have_pt  = 1'b1;
    end else begin
      accumulate(segment_length(prev_pt, v.pt));
    end
    prev_pt = v.pt;
    if (v.last) begin
      if (closed_now == MODE_CLOSED) begin
        accumulate(segment_length(v.pt, first_pt));
        closed_polylines++;
      end else begin
        open_polylines++;
      end
      // Hundredths of a unit, rounded half up.
      scaled = (length_acc * 100 + ROUND_HALF) >> FRAC_BITS;
      owed.hundredths = scaled[pp3d_pkg::OUT_W-1:0];
      owed.sat        = length_sat;
      pending_perimeters = {pending_perimeters, owed};
      first_pt   = '0;
      prev_pt    = '0;
      have_pt    = 1'b0;
      length_acc = 0;
      length_sat = 1'b0;
    end
  endfunction

  // Sender: keeps one word on the bus until it is taken, then offers the next
  // queued point or idles. The prediction is made at the accepting edge.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_vertex(on_bus);
        points_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_points.pop_front();
          s_tdata  <= {on_bus.pt.z, on_bus.pt.y, on_bus.pt.x};
          s_tlast  <= on_bus.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long output stall, counted here so the receiver only has to look at the count.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_served != stalls_asked) begin
      stall_left    <= STALL_CYCLES;
      stalls_served <= stalls_served + 1;
    end
  end

  // Receiver: checks every accepted result word against the oldest owed perimeter.
  always @(posedge clk) begin
    perimeter_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_perimeters.size() == 0) begin
          $error("result word with nothing expected: perimeter_hundredths %0d, saturated %0b",
                 m_tdata[pp3d_pkg::OUT_W-1:0], m_tuser);
          fail_count++;
        end else begin
          want = pending_perimeters.pop_front();
          if (m_tdata[pp3d_pkg::OUT_W-1:0] !== want.hundredths) begin
            $error("perimeter_hundredths: expected %0d, got %0d",
                   want.hundredths, m_tdata[pp3d_pkg::OUT_W-1:0]);
            fail_count++;
          end
          if (m_tdata[pp3d_pkg::OUT_DATA_W-1:pp3d_pkg::OUT_W] !== '0) begin
            $error("m_tdata padding: expected 0, got %0h",
                   m_tdata[pp3d_pkg::OUT_DATA_W-1:pp3d_pkg::OUT_W]);
            fail_count++;
          end
          if (m_tuser !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, m_tuser);
            fail_count++;
          end
          if (want.sat) saturated_seen++;
        end
      end
      m_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_point(input int x, input int y, input int z, input bit last);
    vertex_t v;
    v.pt.x = pp3d_pkg::coord_t'(x);
    v.pt.y = pp3d_pkg::coord_t'(y);
    v.pt.z = pp3d_pkg::coord_t'(z);
    v.last = last;
    pending_points = {pending_points, v};
  endtask

  // Mix of full-range jumps, short steps from the previous value, the extremes,
  // values near the origin and repeats, so both long and tiny segments show up.
  function automatic pp3d_pkg::coord_t next_coord(pp3d_pkg::coord_t near);
    case ($urandom_range(5))
      0, 1:    return pp3d_pkg::coord_t'($urandom);
      2:       return pp3d_pkg::coord_t'(near + $signed($urandom_range(2048)) - 1024);
      3:       return ($urandom_range(1) != 0) ? pp3d_pkg::coord_t'(COORD_MAX)
                                               : pp3d_pkg::coord_t'(COORD_MIN);
      4:       return pp3d_pkg::coord_t'($signed($urandom_range(4095)) - 2048);
      default: return near;
    endcase
  endfunction

  // Whole polylines with random content: mostly short ones, now and then a long one.
  task automatic queue_random_polylines(input int budget);
    vertex_t          v;
    pp3d_pkg::point_t here;
    int               count;
    here = '0;
    while (budget > 0) begin
      count = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
      for (int k = 0; k < count; k++) begin
        here.x = next_coord(here.x);
        here.y = next_coord(here.y);
        here.z = next_coord(here.z);
        v.pt   = here;
        v.last = (k == count - 1);
        pending_points = {pending_points, v};
      end
      budget -= count;
    end
  endtask

  // closed_mode may only change while the block has nothing in flight.
  task automatic write_closed_mode(input bit value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    closed_now = value;
  endtask

  // Sender pause: nothing queued, nothing on the bus, nothing owed, then quiet cycles.
  task automatic wait_drained();
    while (pending_points.size() != 0 || s_tvalid || pending_perimeters.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Traffic settings for the next phase, applied between edges.
  task automatic begin_phase(input int send_pct, input int recv_pct, input bit long_stall);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (long_stall) stalls_asked <= stalls_asked + 1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed polylines in closed mode, light sender idling, heavy receiver idling.
    write_closed_mode(MODE_CLOSED);
    begin_phase(9, 79, 1'b0);
    // A lone point is both first and last; its closing segment is empty.
    push_point(0, 0, 0, 1'b1);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    // Corner to opposite corner and back: the longest possible segments.
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    push_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    push_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    // Unit triangle on the axes.
    push_point(1024, 0, 0, 1'b0);
    push_point(0, 1024, 0, 1'b0);
    push_point(0, 0, 1024, 1'b1);
    // Repeated point: zero-length segments.
    push_point(5, 5, 5, 1'b0);
    push_point(5, 5, 5, 1'b1);
    // Two hops of 64 sum to exactly 12.5 hundredths, which must round up.
    push_point(0, 0, 0, 1'b0);
    push_point(64, 0, 0, 1'b1);
    // Root of a non-square is truncated.
    push_point(-1, -1, -1, 1'b0);
    push_point(0, 0, 0, 1'b1);
    wait_drained();

    // Open mode: a few directed polylines, then random ones.
    write_closed_mode(MODE_OPEN);
    begin_phase(9, 79, 1'b0);
    push_point(7, 7, 7, 1'b1);
    push_point(COORD_MIN, 0, COORD_MAX, 1'b0);
    push_point(COORD_MAX, 0, COORD_MIN, 1'b1);
    push_point(0, 0, 0, 1'b0);
    push_point(128, 0, 0, 1'b1);
    queue_random_polylines(330);
    wait_drained();

    // Closed mode with the idling swapped: sender mostly idle, receiver eager.
    write_closed_mode(MODE_CLOSED);
    begin_phase(79, 9, 1'b0);
    queue_random_polylines(330);
    wait_drained();

    // Back to back in open mode. A long output stall at the start makes one
    // result word sit on m_* and the next one back the input up.
    write_closed_mode(MODE_OPEN);
    begin_phase(0, 0, 1'b1);
    queue_random_polylines(335);
    wait_drained();

    // One long closed polyline of corner hops, so the sum grows large.
    write_closed_mode(MODE_CLOSED);
    begin_phase(0, 0, 1'b0);
    for (int k = 0; k < CORNER_HOPS; k++) begin
      if (k % 2 == 0) push_point(COORD_MIN, COORD_MIN, COORD_MIN, k == CORNER_HOPS - 1);
      else push_point(COORD_MAX, COORD_MAX, COORD_MAX, k == CORNER_HOPS - 1);
    end
    wait_drained();

    $display("Covered %0d points in %0d open and %0d closed polylines, %0d results checked,",
             points_taken, open_polylines, closed_polylines, results_seen);
    $display("%0d of them with a clamped sum, under idle, swapped-idle and stalled traffic.",
             saturated_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pp3d_pkg.sv
hw/rtl/pp3d_sqdist.sv
hw/rtl/pp3d_isqrt.sv
hw/rtl/polyline_perimeter_3d_core.sv
hw/rtl/pp3d_checker.sv
tb/tb_top.sv
